FILE: hdl/hpc_pkg.sv
// shared types and constants for the heater proportional controller
// no dependencies
`timescale 1ns / 1ps

package hpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALF   = 3'd4;

    // reset values of the registers
    localparam logic [8:0] SETPOINT_RST    = 9'd300;
    localparam logic [7:0] GAIN_RST        = 8'd70;
    localparam logic [3:0] OFFSET_RST      = 4'd3;
    localparam logic [3:0] SPIKE_LIMIT_RST = 4'd3;
    localparam logic [5:0] BAND_HALF_RST   = 6'd10;

    typedef struct packed {
        logic [8:0] setpoint;
        logic [7:0] gain;
        logic [3:0] offset;
        logic [3:0] spike_limit;
        logic [5:0] band_half;
    } t_cfg;

    typedef struct packed {
        logic [9:0] drive;
        logic [8:0] temperature;
        logic       in_band;
        logic       rejected;
    } t_result;

endpackage

FILE: hdl/hpc_datapath.sv
// conversion, spike rejection, proportional drive and band check for one sample
// depends on hpc_pkg
`timescale 1ns / 1ps

module hpc_datapath #(
    parameter int DRIVE_MAX = 1023,
    parameter int ADC_ZERO  = 1000
) (
    input  hpc_pkg::t_cfg    i_cfg,
    input  logic [9:0]       i_adc_sample,
    input  logic [8:0]       i_last_good,
    input  logic             i_primed,
    output hpc_pkg::t_result o_result
);
    import hpc_pkg::*;

    localparam logic [9:0]  ZERO    = 10'(ADC_ZERO);
    localparam logic [19:0] DMAX    = 20'(DRIVE_MAX);
    localparam logic [9:0]  DMAX_LO = 10'(DRIVE_MAX);

    logic [9:0]         w_span;
    logic [8:0]         w_now;
    logic signed [9:0]  w_delta;
    logic [9:0]         w_mag;
    logic               w_spike;
    logic [8:0]         w_temp;
    logic signed [10:0] w_err;
    logic signed [19:0] w_gain_s;
    logic signed [19:0] w_err_s;
    logic signed [19:0] w_prod;
    logic signed [10:0] w_t;
    logic signed [10:0] w_lo;
    logic signed [10:0] w_hi;

    always_comb begin
        w_span  = ZERO - i_adc_sample;
        w_now   = (i_adc_sample > ZERO) ? 9'd0 : w_span[9:1];

        w_delta = $signed({1'b0, w_now}) - $signed({1'b0, i_last_good});
        w_mag   = w_delta[9] ? 10'(-w_delta) : 10'(w_delta);
        // before the first transfer every sample is taken
        w_spike = i_primed && (w_mag > {6'd0, i_cfg.spike_limit});
        w_temp  = w_spike ? i_last_good : w_now;

        w_err    = $signed({2'b00, i_cfg.setpoint}) - $signed({2'b00, w_temp})
                 + $signed({7'd0, i_cfg.offset});
        w_gain_s = $signed({12'd0, i_cfg.gain});
        w_err_s  = 20'(w_err);
        w_prod   = w_gain_s * w_err_s;

        w_t  = $signed({2'b00, w_temp});
        w_lo = $signed({2'b00, i_cfg.setpoint}) - $signed({5'd0, i_cfg.band_half});
        w_hi = $signed({2'b00, i_cfg.setpoint}) + $signed({5'd0, i_cfg.band_half});

        priority if (w_prod[19]) begin
            o_result.drive = 10'd0;
        end else if (20'(w_prod) > DMAX) begin
            o_result.drive = DMAX_LO;
        end else begin
            o_result.drive = w_prod[9:0];
        end
        o_result.temperature = w_temp;
        o_result.in_band     = (w_t > w_lo) && (w_t < w_hi);
        o_result.rejected    = w_spike;
    end

endmodule

FILE: hdl/heater_proportional_control.sv
// top level of the heater proportional controller: config registers, state, result register
// depends on hpc_pkg and hpc_datapath
`timescale 1ns / 1ps

// Takes one 10-bit converter sample per transfer and returns one result per sample:
// the spike-filtered temperature, the saturated heater drive, an in-band flag and a
// rejected flag. One sample can be taken every cycle while the output is not stalled; its
// result is registered and appears in the cycle after the input transfer, held in a single
// output register that is reloaded in the same cycle it is drained, so throughput is one
// sample per cycle unless a held result is stalled. Configuration writes are always ready and
// take effect on the next sample; indexes beyond the register list are ignored.
module heater_proportional_control #(
    parameter int DRIVE_MAX = 1023,
    parameter int ADC_ZERO  = 1000
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [9:0]                       i_adc_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [9:0]                       o_drive,
    output logic [8:0]                       o_temperature,
    output logic                             o_in_band,
    output logic                             o_rejected,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hpc_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic [8:0] r_last_good;
    logic       r_primed;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_in_xfer;

    hpc_datapath #(
        .DRIVE_MAX (DRIVE_MAX),
        .ADC_ZERO  (ADC_ZERO)
    ) u_datapath (
        .i_cfg        (r_cfg),
        .i_adc_sample (i_adc_sample),
        .i_last_good  (r_last_good),
        .i_primed     (r_primed),
        .o_result     (w_result)
    );

    assign o_cfg_ready = 1'b1;
    // input may transfer whenever the result register is empty or being drained
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SETPOINT:    n_cfg.setpoint    = i_cfg_data[8:0];
                CFG_GAIN:        n_cfg.gain        = i_cfg_data[7:0];
                CFG_OFFSET:      n_cfg.offset      = i_cfg_data[3:0];
                CFG_SPIKE_LIMIT: n_cfg.spike_limit = i_cfg_data[3:0];
                CFG_BAND_HALF:   n_cfg.band_half   = i_cfg_data[5:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint    <= SETPOINT_RST;
            r_cfg.gain        <= GAIN_RST;
            r_cfg.offset      <= OFFSET_RST;
            r_cfg.spike_limit <= SPIKE_LIMIT_RST;
            r_cfg.band_half   <= BAND_HALF_RST;
            r_last_good       <= 9'd0;
            r_primed          <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (w_in_xfer) begin
                r_out_valid <= 1'b1;
                r_primed    <= 1'b1;
                if (!w_result.rejected) begin
                    r_last_good <= w_result.temperature;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_out.drive;
    assign o_temperature = r_out.temperature;
    assign o_in_band     = r_out.in_band;
    assign o_rejected    = r_out.rejected;

`ifndef SYNTHESIS
    // the held result always matches the stored last accepted temperature
    a_temp_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature == r_last_good))
        else $error("held temperature differs from last accepted temperature");

    a_primed_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_primed)
        else $error("result present before first sample was taken");

    // temperature above setpoint plus offset gives a negative error
    a_drive_off_when_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ({1'b0, o_temperature} >
            ({1'b0, r_cfg.setpoint} + {6'd0, r_cfg.offset}))) |-> (o_drive == 10'd0))
        else $error("drive not zero for temperature above target");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_accept_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_out_valid)
        else $error("input transfer did not produce a result");
`endif

endmodule

FILE: dv/heater_proportional_control_tb.sv
// self-checking testbench for heater_proportional_control: directed samples, then random
// walks and noise under several register settings; results checked against a local model
// depends on hpc_pkg and heater_proportional_control
`timescale 1ns / 1ps

module heater_proportional_control_tb;
    import hpc_pkg::*;

    localparam int ADC_ZERO    = 1000;
    localparam int DRIVE_MAX   = 1023;
    localparam int TEMP_MAX    = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int RESULT_LAT  = 1;
    localparam int PHASE_ITEMS = 235;
    localparam int PRINT_MAX   = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [9:0]            i_adc_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [9:0]            o_drive;
    logic [8:0]            o_temperature;
    logic                  o_in_band;
    logic                  o_rejected;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    heater_proportional_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_adc_sample  (i_adc_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .o_temperature (o_temperature),
        .o_in_band     (o_in_band),
        .o_rejected    (o_rejected),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // controller mirror: registers and filter state
    t_cfg        cfg_mirror = '{SETPOINT_RST, GAIN_RST, OFFSET_RST, SPIKE_LIMIT_RST, BAND_HALF_RST};
    int          last_temp  = 0;
    bit          primed     = 1'b0;

    logic [9:0]  sample_q[$];
    t_result     result_q[$];

    bit          idle_on     = 1'b1;
    int          hold_asked  = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          stall_left  = 0;
    int          send_gap    = 0;
    int          idle_cycles = 0;

    int          n_errors   = 0;
    int          n_samples  = 0;
    int          n_results  = 0;
    int          n_rejected = 0;
    int          n_in_band  = 0;
    int          n_drv_max  = 0;
    int          n_drv_zero = 0;

    function automatic t_result heater_step(input logic [9:0] sample);
        int      s;
        int      now_t;
        int      temp;
        int      diff;
        int      prod;
        int      sp;
        int      bh;
        t_result r;
        s = int'(sample);
        now_t = (s > ADC_ZERO) ? 0 : (ADC_ZERO - s) / 2;
        r.rejected = 1'b0;
        if (!primed) begin
            temp = now_t;
            last_temp = now_t;
            primed = 1'b1;
        end else begin
            diff = now_t - last_temp;
            if (diff < 0) diff = -diff;
            if (diff > int'(cfg_mirror.spike_limit)) begin
                temp = last_temp;
                r.rejected = 1'b1;
            end else begin
                temp = now_t;
                last_temp = now_t;
            end
        end
        sp = int'(cfg_mirror.setpoint);
        bh = int'(cfg_mirror.band_half);
        prod = int'(cfg_mirror.gain) * (sp - temp + int'(cfg_mirror.offset));
        if (prod < 0) prod = 0;
        if (prod > DRIVE_MAX) prod = DRIVE_MAX;
        r.drive       = 10'(prod);
        r.temperature = 9'(temp);
        r.in_band     = (temp > sp - bh) && (temp < sp + bh);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < PRINT_MAX)
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_adc_sample <= sample_q.pop_front();
                i_in_valid   <= 1'b1;
                send_gap = (idle_on && $urandom_range(0, 99) < 25) ? gap_len() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = gap_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: register writes, sample transfers, result checks, watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                idle_cycles = 0;
                case (i_cfg_index)
                    CFG_SETPOINT:    cfg_mirror.setpoint    = i_cfg_data[8:0];
                    CFG_GAIN:        cfg_mirror.gain        = i_cfg_data[7:0];
                    CFG_OFFSET:      cfg_mirror.offset      = i_cfg_data[3:0];
                    CFG_SPIKE_LIMIT: cfg_mirror.spike_limit = i_cfg_data[3:0];
                    CFG_BAND_HALF:   cfg_mirror.band_half   = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                idle_cycles = 0;
                n_samples++;
                result_q.push_back(heater_step(i_adc_sample));
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                n_results++;
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = result_q.pop_front();
                    if (o_drive !== want.drive)
                        report_mismatch("drive", int'(o_drive), int'(want.drive));
                    if (o_temperature !== want.temperature)
                        report_mismatch("temperature", int'(o_temperature),
                                        int'(want.temperature));
                    if (o_in_band !== want.in_band)
                        report_mismatch("in_band", int'(o_in_band), int'(want.in_band));
                    if (o_rejected !== want.rejected)
                        report_mismatch("rejected", int'(o_rejected), int'(want.rejected));
                    n_rejected += want.rejected;
                    n_in_band  += want.in_band;
                    n_drv_max  += (want.drive == 10'(DRIVE_MAX));
                    n_drv_zero += (want.drive == '0);
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // wait until every sample is sent and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || result_q.size() != 0);
        repeat (RESULT_LAT + 1) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    // junk in the unused high bits, plus one write to an unused index
    task automatic set_config(input int sp, input int g, input int off, input int spk, input int bh);
        @(posedge i_clk);
        cfg_write(CFG_SETPOINT, 9'(sp));
        cfg_write(CFG_GAIN, {1'($urandom), 8'(g)});
        cfg_write(CFG_OFFSET, {5'($urandom), 4'(off)});
        cfg_write(CFG_SPIKE_LIMIT, {5'($urandom), 4'(spk)});
        cfg_write(CFG_BAND_HALF, {3'($urandom), 6'(bh)});
        cfg_write(CFG_BAND_HALF + 3'($urandom_range(1, 3)), 9'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int temp_to_sample(input int t);
        int s;
        s = ADC_ZERO - 2 * t;
        if (t == 0 && $urandom_range(0, 3) == 0) return $urandom_range(ADC_ZERO, 1023);
        if (s > 0 && $urandom_range(0, 1) == 1) s--;
        return s;
    endfunction

    function automatic int pick_target();
        int t;
        int bh;
        bh = int'(cfg_mirror.band_half);
        if ($urandom_range(0, 1) == 0)
            t = int'(cfg_mirror.setpoint) + $urandom_range(0, 2 * bh + 4) - (bh + 2);
        else
            t = $urandom_range(0, TEMP_MAX);
        if (t < 0) t = 0;
        if (t > TEMP_MAX) t = TEMP_MAX;
        return t;
    endfunction

    // slow ramps toward moving targets, with noise, extremes and just-too-large jumps
    task automatic push_random(input int n);
        int wt;
        int tgt;
        int spk;
        int step;
        int jt;
        int r;
        int k;
        int corner[7];
        corner = '{0, 1023, ADC_ZERO, ADC_ZERO + 1, ADC_ZERO - 1, 511, 512};
        spk = int'(cfg_mirror.spike_limit);
        wt  = last_temp;
        tgt = pick_target();
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                if (wt == tgt) tgt = pick_target();
                step = $urandom_range(0, spk);
                if (r < 8) begin
                    wt = (tgt > wt) ? wt - step : wt + step;
                end else if (tgt > wt) begin
                    wt = (tgt - wt < step) ? tgt : wt + step;
                end else begin
                    wt = (wt - tgt < step) ? tgt : wt - step;
                end
                if (wt < 0) wt = 0;
                if (wt > TEMP_MAX) wt = TEMP_MAX;
                sample_q.push_back(10'(temp_to_sample(wt)));
            end else if (r < 84) begin
                sample_q.push_back(10'($urandom_range(0, 1023)));
            end else if (r < 92) begin
                sample_q.push_back(10'(corner[$urandom_range(0, 6)]));
            end else begin
                jt = wt + spk + 1 + $urandom_range(0, 3);
                if (jt > TEMP_MAX) jt = wt - spk - 1 - $urandom_range(0, 3);
                if (jt < 0) jt = wt;
                sample_q.push_back(10'(temp_to_sample(jt)));
            end
        end
    endtask

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 4);
        if (r < 8) return $urandom_range(5, 40);
        return $urandom_range(0, 255);
    endfunction

    initial begin
        int ph;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_adc_sample = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_SETPOINT;
        i_cfg_data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: first sample primes, above-zero samples, limit edge, spikes
        sample_q = '{10'd1023, 10'd1001, 10'd1000, 10'd999, 10'd994, 10'd985, 10'd0,
                     10'd993, 10'd1023};
        wait_drained();
        // window below zero, negative error gives zero drive, widest spike limit
        set_config(0, 255, 0, 15, 63);
        sample_q = '{10'd1000, 10'd990, 10'd970, 10'd940, 10'd938, 10'd0, 10'd938};
        wait_drained();
        // zero spike limit, zero band, drive saturates high
        set_config(511, 255, 15, 0, 0);
        sample_q = '{10'd938, 10'd937, 10'd936, 10'd1023};
        wait_drained();
        // zero gain, window edges
        set_config(40, 0, 7, 15, 1);
        sample_q = '{10'd930, 10'd921, 10'd920};
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0)
                set_config(511, 255, 15, 15, 63);
            else if (ph == 1)
                set_config(0, 0, 0, 0, 0);
            else
                set_config($urandom_range(0, 511), pick_gain(), $urandom_range(0, 15),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(2, 15),
                           $urandom_range(0, 63));
            idle_on = (ph != 3);
            // long receiver hold while the sender keeps offering
            if (ph == 2 || ph == 5) hold_asked++;
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (4) @(negedge i_clk);
        if (result_q.size() != 0)
            report_mismatch("results still pending", result_q.size(), 0);
        $display("%0d samples, %0d results: %0d spikes rejected, %0d in band",
                 n_samples, n_results, n_rejected, n_in_band);
        $display("drive at full scale %0d times, at zero %0d times; %0d mismatches",
                 n_drv_max, n_drv_zero, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hpc_pkg.sv
hdl/hpc_datapath.sv
hdl/heater_proportional_control.sv
dv/heater_proportional_control_tb.sv
